@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// invariant
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

@@ hdl/lfb_pkg.sv @@
// ----------------------------------------------------------------------------
// lfb_pkg
// Constants, types and the quarter-wave sine table for the LED driver.
// ----------------------------------------------------------------------------
`default_nettype none

package lfb_pkg;

   localparam int PWM_SLOTS  = 10;
   localparam int SINE_STEPS = 1024;

   localparam int SINE_BITS  = $clog2(SINE_STEPS);
   localparam int QUARTER    = SINE_STEPS / 4;
   localparam int QTR_BITS   = SINE_BITS - 2;
   localparam int CNT_W      = $clog2(SINE_BITS);
   localparam int MAG_W      = 16;
   localparam int SUM_W      = MAG_W + 1;
   localparam int DUTY_W     = $clog2(PWM_SLOTS + 1);
   localparam int SLOT_W     = $clog2(PWM_SLOTS);
   localparam int PROD_W     = SUM_W + DUTY_W;
   localparam int DUTY_OUT_W = 4;

   localparam int PERIOD_W   = 16;
   localparam int CYCLES_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_PERIOD  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_CYCLES  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_BREATH_ON     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_BREATH_PERIOD = CSR_IDX_W'(3);

   localparam logic [PERIOD_W-1:0] FLASH_PERIOD_RST = PERIOD_W'(500);
   localparam logic [SUM_W-1:0]    SINE_OFFSET      = SUM_W'(32768);

   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic look;
      logic duty;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic breath_go;
   } status_type;

   typedef logic [MAG_W-1:0] mag_tab_type [QUARTER];

   // |sin| in Q15 for a quarter-wave position rem (0..SINE_STEPS), Taylor form
   function automatic logic [MAG_W-1:0] sine_mag(input int unsigned rem);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned m;
      x  = (HALF_PI_Q30 * 64'(rem)) / SINE_STEPS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      m  = (s + 64'd16384) >> 15;
      return MAG_W'(m);
   endfunction

   function automatic mag_tab_type build_mag_tab();
      mag_tab_type tab;
      for (int k = 0; k < QUARTER; k++) begin
         tab[k] = sine_mag(int'(4 * k));
      end
      return tab;
   endfunction

   localparam mag_tab_type      MAG_TAB  = build_mag_tab();
   localparam logic [MAG_W-1:0] MAG_FULL = sine_mag(SINE_STEPS);

endpackage

`default_nettype wire

@@ hdl/led_flash_and_breath_driver.sv @@
// ----------------------------------------------------------------------------
// led_flash_and_breath_driver
// Millisecond-tick LED driver: LED1 flasher, LED2 sine-breathing PWM.
// ----------------------------------------------------------------------------
//  port group  | direction | contents
//  req_*       | in        | tick, boost_on; valid (stall is an output)
//  rsp_*       | out       | led1_on, led2_on, breath_duty; valid (stall is an input)
//  csr_*       | in        | write enable, register index, write data
//
//  A request without a breathing update goes from intake to the response load.
//  A breathing update runs 1 intake, 10 serial divide steps (one quotient
//  bit each), 1 sine table read, 1 duty/PWM update and 1 load.
//  One request is in flight at a time; the response register lets the next
//  request in while the previous response is still stalled.
//  Reset is synchronous and restores all settings to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module led_flash_and_breath_driver (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_tick,
   input  wire logic                            req_boost_on,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_led1_on,
   output logic                                 rsp_led2_on,
   output logic [lfb_pkg::DUTY_OUT_W-1:0]       rsp_breath_duty,
   input  wire logic                            csr_we,
   input  wire logic [lfb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [lfb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lfb_pkg::*;

   cmd_type    cmd;
   status_type status;

   lfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lfb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_tick         (req_tick),
      .req_boost_on     (req_boost_on),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_led1_on      (rsp_led1_on),
      .rsp_led2_on      (rsp_led2_on),
      .rsp_breath_duty  (rsp_breath_duty)
   );

   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "request taken while busy")
   `ASSERT_ALWAYS(a_cmd_exclusive, clock, reset, $onehot0({cmd.accept, cmd.div_step, cmd.look, cmd.duty, cmd.rsp_load}), "overlapping datapath commands")
   `ASSERT_IMPLIES(a_duty_range, clock, reset, rsp_valid, 32'(rsp_breath_duty) <= PWM_SLOTS, "duty beyond slot count")
   `ASSERT_NEXT(a_look_then_duty, clock, reset, cmd.look, cmd.duty, "duty update did not follow table read")

endmodule

`default_nettype wire

@@ hdl/lfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfb_ctrl
// Sequencer: request intake, divide steps, table look-up, duty update, response.
// ----------------------------------------------------------------------------
`default_nettype none

module lfb_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire lfb_pkg::status_type status,
   output lfb_pkg::cmd_type        cmd
);
   import lfb_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_LOOK = 3'd2;
   localparam logic [2:0] ST_DUTY = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               state_in   = status.breath_go ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SINE_BITS - 1)) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = ST_DUTY;
         end
         ST_DUTY: begin
            cmd.duty = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ hdl/lfb_dp.sv @@
// ----------------------------------------------------------------------------
// lfb_dp
// Datapath: settings, LED state, serial phase divider, sine look-up, PWM.
// ----------------------------------------------------------------------------
`default_nettype none

module lfb_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tick,
   input  wire logic                            req_boost_on,
   input  wire logic                            csr_we,
   input  wire logic [lfb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [lfb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire lfb_pkg::cmd_type                cmd,
   output lfb_pkg::status_type                  status,
   output logic                                 rsp_led1_on,
   output logic                                 rsp_led2_on,
   output logic [lfb_pkg::DUTY_OUT_W-1:0]       rsp_breath_duty
);
   import lfb_pkg::*;

   // settings
   logic [PERIOD_W-1:0] flash_period_ff, flash_period_in;
   logic [CYCLES_W-1:0] flash_cycles_ff, flash_cycles_in;
   logic                breath_on_ff, breath_on_in;
   logic [PERIOD_W-1:0] breath_period_ff, breath_period_in;

   // working state
   logic [PERIOD_W-1:0] live_period_ff, live_period_in;
   logic [CYCLES_W-1:0] cycles_left_ff, cycles_left_in;
   logic [PERIOD_W-1:0] flash_ticks_ff, flash_ticks_in;
   logic                flash_level_ff, flash_level_in;
   logic [PERIOD_W-1:0] breath_ticks_ff, breath_ticks_in;
   logic [SLOT_W-1:0]   pwm_slot_ff, pwm_slot_in;
   logic                breath_level_ff, breath_level_in;
   logic [DUTY_W-1:0]   last_duty_ff, last_duty_in;

   // divider and look-up
   logic [PERIOD_W-1:0]  div_rem_ff, div_rem_in;
   logic [SINE_BITS-1:0] quot_ff, quot_in;
   logic [MAG_W-1:0]     mag_ff;
   logic                 neg_ff;

   logic                 rsp_led1_ff, rsp_led2_ff;
   logic [DUTY_OUT_W-1:0] rsp_duty_ff;

   logic                flash_reload, breath_reload;
   logic [PERIOD_W-1:0] ft_inc, bt_inc;
   logic [PERIOD_W:0]   div_trial;
   logic [QTR_BITS-1:0] qtr_idx, qtr_mirror;
   logic [1:0]          quad;
   logic [MAG_W-1:0]    mag_sel;
   logic [SUM_W-1:0]    duty_sum;
   logic [PROD_W-1:0]   duty_prod;
   logic [DUTY_W-1:0]   duty_new;
   logic [SLOT_W-1:0]   slot_next;
   logic [DUTY_W+DUTY_OUT_W-1:0] duty_ext;

   assign status.breath_go = req_tick && req_boost_on && breath_on_ff &&
                             (breath_period_ff != '0);

   // settings writes
   always_comb begin
      flash_period_in  = flash_period_ff;
      flash_cycles_in  = flash_cycles_ff;
      breath_on_in     = breath_on_ff;
      breath_period_in = breath_period_ff;
      flash_reload     = 1'b0;
      breath_reload    = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_FLASH_PERIOD: begin
               flash_period_in = csr_wdata[PERIOD_W-1:0];
               flash_reload    = 1'b1;
            end
            CSR_FLASH_CYCLES: begin
               flash_cycles_in = csr_wdata[CYCLES_W-1:0];
               flash_reload    = 1'b1;
            end
            CSR_BREATH_ON: begin
               breath_on_in  = csr_wdata[0];
               breath_reload = 1'b1;
            end
            CSR_BREATH_PERIOD: begin
               breath_period_in = csr_wdata[PERIOD_W-1:0];
               breath_reload    = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // LED1 flasher
   assign ft_inc = flash_ticks_ff + 1'b1;

   always_comb begin
      live_period_in = live_period_ff;
      cycles_left_in = cycles_left_ff;
      flash_ticks_in = flash_ticks_ff;
      flash_level_in = flash_level_ff;
      if (flash_reload) begin
         live_period_in = flash_period_in;
         cycles_left_in = flash_cycles_in;
         flash_ticks_in = '0;
         flash_level_in = (flash_period_in == '0) ? (flash_cycles_in != '0) : 1'b0;
      end else if (cmd.accept && req_tick && (live_period_ff != '0)) begin
         flash_ticks_in = ft_inc;
         if (ft_inc >= live_period_ff) begin
            flash_ticks_in = '0;
            flash_level_in = !flash_level_ff;
            // falling edge ends one cycle
            if ((cycles_left_ff != '0) && flash_level_ff) begin
               cycles_left_in = cycles_left_ff - 1'b1;
               if (cycles_left_ff == CYCLES_W'(1)) begin
                  live_period_in = '0;
               end
            end
         end
      end
   end

   // LED2 breathing
   assign bt_inc    = breath_ticks_ff + 1'b1;
   assign div_trial = {div_rem_ff, 1'b0};

   assign quad       = quot_ff[SINE_BITS-1 -: 2];
   assign qtr_idx    = quot_ff[QTR_BITS-1:0];
   assign qtr_mirror = '0 - qtr_idx;

   always_comb begin
      if (!quad[0]) begin
         mag_sel = MAG_TAB[qtr_idx];
      end else if (qtr_idx == '0) begin
         mag_sel = MAG_FULL;
      end else begin
         mag_sel = MAG_TAB[qtr_mirror];
      end
   end

   assign duty_sum  = neg_ff ? (SINE_OFFSET - SUM_W'(mag_ff)) : (SINE_OFFSET + SUM_W'(mag_ff));
   assign duty_prod = PROD_W'(duty_sum) * PROD_W'(PWM_SLOTS);
   assign duty_new  = duty_prod[MAG_W +: DUTY_W];
   assign slot_next = (pwm_slot_ff == SLOT_W'(PWM_SLOTS - 1)) ? '0 : pwm_slot_ff + 1'b1;

   always_comb begin
      breath_ticks_in = breath_ticks_ff;
      breath_level_in = breath_level_ff;
      pwm_slot_in     = pwm_slot_ff;
      last_duty_in    = last_duty_ff;
      if (breath_reload) begin
         breath_ticks_in = '0;
         if (!breath_on_in) begin
            breath_level_in = 1'b0;
         end else if (breath_period_in == '0) begin
            breath_level_in = 1'b1;
         end
      end else if (cmd.accept && status.breath_go) begin
         breath_ticks_in = (bt_inc >= breath_period_ff) ? '0 : bt_inc;
      end else if (cmd.duty) begin
         last_duty_in    = duty_new;
         pwm_slot_in     = slot_next;
         breath_level_in = (DUTY_W'(slot_next) < duty_new);
      end
   end

   // restoring divide: quotient bits of ticks * SINE_STEPS / period
   always_comb begin
      div_rem_in = div_rem_ff;
      quot_in    = quot_ff;
      if (cmd.accept) begin
         div_rem_in = breath_ticks_in;
         quot_in    = '0;
      end else if (cmd.div_step) begin
         if (div_trial >= {1'b0, breath_period_ff}) begin
            div_rem_in = PERIOD_W'(div_trial - {1'b0, breath_period_ff});
            quot_in    = {quot_ff[SINE_BITS-2:0], 1'b1};
         end else begin
            div_rem_in = div_trial[PERIOD_W-1:0];
            quot_in    = {quot_ff[SINE_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_period_ff  <= FLASH_PERIOD_RST;
         flash_cycles_ff  <= '0;
         breath_on_ff     <= 1'b0;
         breath_period_ff <= '0;
         live_period_ff   <= FLASH_PERIOD_RST;
         cycles_left_ff   <= '0;
         flash_ticks_ff   <= '0;
         flash_level_ff   <= 1'b0;
         breath_ticks_ff  <= '0;
         pwm_slot_ff      <= '0;
         breath_level_ff  <= 1'b0;
         last_duty_ff     <= '0;
      end else begin
         flash_period_ff  <= flash_period_in;
         flash_cycles_ff  <= flash_cycles_in;
         breath_on_ff     <= breath_on_in;
         breath_period_ff <= breath_period_in;
         live_period_ff   <= live_period_in;
         cycles_left_ff   <= cycles_left_in;
         flash_ticks_ff   <= flash_ticks_in;
         flash_level_ff   <= flash_level_in;
         breath_ticks_ff  <= breath_ticks_in;
         pwm_slot_ff      <= pwm_slot_in;
         breath_level_ff  <= breath_level_in;
         last_duty_ff     <= last_duty_in;
      end
   end

   assign duty_ext = {{DUTY_OUT_W{1'b0}}, last_duty_ff};

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      quot_ff    <= quot_in;
      if (cmd.look) begin
         mag_ff <= mag_sel;
         neg_ff <= quad[1];
      end
      if (cmd.rsp_load) begin
         rsp_led1_ff <= flash_level_ff;
         rsp_led2_ff <= breath_level_ff;
         rsp_duty_ff <= duty_ext[DUTY_OUT_W-1:0];
      end
   end

   assign rsp_led1_on     = rsp_led1_ff;
   assign rsp_led2_on     = rsp_led2_ff;
   assign rsp_breath_duty = rsp_duty_ff;

endmodule

`default_nettype wire

@@ tb/sv/led_flash_and_breath_driver_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_flash_and_breath_driver_tb
// Self-checking bench for the LED flasher and breathing driver. A scoreboard
// class keeps its own copy of the settings and LED state, predicts the levels
// for every accepted request and compares each response field by field.
// Directed requests cover the corner settings; random phases then reprogram
// the block and stream mostly-ticking requests with random gaps and stalls.
// ----------------------------------------------------------------------------
module led_flash_and_breath_driver_tb;

   import lfb_pkg::*;

   localparam int GAP_MAX        = 16;
   localparam int RESET_CYCLES   = 5;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;
   localparam int PRINT_CAP      = 40;
   localparam int RANDOM_PHASES  = 12;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(7);

   typedef struct packed {
      logic                  led1;
      logic                  led2;
      logic [DUTY_OUT_W-1:0] duty;
   } led_levels_type;

   class led_level_scoreboard;
      logic [PERIOD_W-1:0] flash_period_cfg;
      logic [CYCLES_W-1:0] flash_cycles_cfg;
      logic                breath_on_cfg;
      logic [PERIOD_W-1:0] breath_period_cfg;

      logic [PERIOD_W-1:0] flash_span;
      logic [CYCLES_W-1:0] led1_left;
      logic [PERIOD_W-1:0] flash_count;
      logic                led1_level;
      logic [PERIOD_W-1:0] led2_count;
      int unsigned         led2_slot;
      logic                led2_level;
      int unsigned         led2_duty;

      led_levels_type expected_levels [$];
      int             mismatches;

      function new();
         flash_period_cfg  = FLASH_PERIOD_RST;
         flash_cycles_cfg  = '0;
         breath_on_cfg     = 1'b0;
         breath_period_cfg = '0;
         flash_span        = FLASH_PERIOD_RST;
         led1_left         = '0;
         flash_count       = '0;
         led1_level        = 1'b0;
         led2_count        = '0;
         led2_slot         = 0;
         led2_level        = 1'b0;
         led2_duty         = 0;
         mismatches        = 0;
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      // Q1.15 sine of step/SINE_STEPS of a turn, Taylor series in Q30
      function int sine_sample(int unsigned step);
         longint unsigned steps4, quad, rem, x, x2, t, s, mag;
         longint unsigned divs [5];
         divs   = '{110, 72, 42, 20, 6};
         steps4 = 64'(step) * 4;
         quad   = steps4 / SINE_STEPS;
         rem    = steps4 % SINE_STEPS;
         if (quad % 2 == 1) begin
            rem = SINE_STEPS - rem;
         end
         x  = (HALF_PI_Q30 * rem) / SINE_STEPS;
         x2 = (x * x) >> 30;
         t  = Q30_ONE;
         foreach (divs[k]) begin
            t = Q30_ONE - ((x2 * t) >> 30) / divs[k];
         end
         s   = (x * t) >> 30;
         mag = (s + 64'd16384) >> 15;
         return (quad >= 2) ? -int'(mag) : int'(mag);
      endfunction

      function void flash_reload();
         flash_span  = flash_period_cfg;
         led1_left   = flash_cycles_cfg;
         flash_count = '0;
         led1_level  = (flash_period_cfg == 0) ? (flash_cycles_cfg != 0) : 1'b0;
      endfunction

      function void breath_reload();
         led2_count = '0;
         if (!breath_on_cfg) begin
            led2_level = 1'b0;
         end else if (breath_period_cfg == 0) begin
            led2_level = 1'b1;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FLASH_PERIOD: begin
               flash_period_cfg = data[PERIOD_W-1:0];
               flash_reload();
            end
            CSR_FLASH_CYCLES: begin
               flash_cycles_cfg = data[CYCLES_W-1:0];
               flash_reload();
            end
            CSR_BREATH_ON: begin
               breath_on_cfg = data[0];
               breath_reload();
            end
            CSR_BREATH_PERIOD: begin
               breath_period_cfg = data[PERIOD_W-1:0];
               breath_reload();
            end
            default: ;
         endcase
      endfunction

      function void note_request(logic tick, logic boost);
         int unsigned    step;
         int             wave;
         led_levels_type lv;
         if (tick) begin
            if (flash_span != 0) begin
               flash_count = flash_count + 1'b1;
               if (flash_count >= flash_span) begin
                  flash_count = '0;
                  led1_level  = ~led1_level;
                  // a falling toggle completes one flash cycle
                  if (led1_left != 0 && !led1_level) begin
                     led1_left = led1_left - 1'b1;
                     if (led1_left == 0) begin
                        flash_span = '0;
                     end
                  end
               end
            end
            if (breath_on_cfg && breath_period_cfg != 0 && boost) begin
               led2_count = led2_count + 1'b1;
               if (led2_count >= breath_period_cfg) begin
                  led2_count = '0;
               end
               step      = (int'(led2_count) * SINE_STEPS) / int'(breath_period_cfg);
               wave      = sine_sample(step);
               led2_duty = (PWM_SLOTS * (wave + int'(SINE_OFFSET))) >> 16;
               led2_slot++;
               if (led2_slot >= PWM_SLOTS) begin
                  led2_slot = 0;
               end
               led2_level = (led2_slot < led2_duty);
            end
         end
         lv.led1 = led1_level;
         lv.led2 = led2_level;
         lv.duty = DUTY_OUT_W'(led2_duty);
         expected_levels.push_back(lv);
      endfunction

      task report(string what);
         if (mismatches < PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
         end
         mismatches++;
      endtask

      task check_response(logic led1, logic led2, logic [DUTY_OUT_W-1:0] duty);
         led_levels_type lv;
         if (expected_levels.size() == 0) begin
            report("response with no request outstanding");
         end else begin
            lv = expected_levels.pop_front();
            if (led1 !== lv.led1) begin
               report($sformatf("led1_on %b, expected %b", led1, lv.led1));
            end
            if (led2 !== lv.led2) begin
               report($sformatf("led2_on %b, expected %b", led2, lv.led2));
            end
            if (duty !== lv.duty) begin
               report($sformatf("breath_duty %0d, expected %0d", duty, lv.duty));
            end
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_tick;
   logic                  req_boost_on;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_led1_on;
   logic                  rsp_led2_on;
   logic [DUTY_OUT_W-1:0] rsp_breath_duty;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   led_level_scoreboard levels = new();
   logic                calm;
   int                  idle_cycles;

   led_flash_and_breath_driver u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_tick         (req_tick),
      .req_boost_on     (req_boost_on),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_led1_on      (rsp_led1_on),
      .rsp_led2_on      (rsp_led2_on),
      .rsp_breath_duty  (rsp_breath_duty),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int draw_gap();
      if (calm) begin
         return 0;
      end
      return $urandom_range(0, GAP_MAX);
   endfunction

   // valid is left high after acceptance so back-to-back requests never pulse it
   task automatic send_request(input logic tick, input logic boost);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_tick     <= tick;
      req_boost_on <= boost;
      do @(posedge clock); while (req_stall);
      levels.note_request(tick, boost);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (levels.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      levels.write_reg(idx, data);
   endtask

   task automatic finish_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : response_side
      int hold;
      hold      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            levels.check_response(rsp_led1_on, rsp_led2_on, rsp_breath_duty);
            hold = draw_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [CSR_IDX_W-1:0]  order [4];
      logic [CSR_IDX_W-1:0]  tmp;
      logic [CSR_DATA_W-1:0] data;
      logic [PERIOD_W-1:0]   fp;
      logic [PERIOD_W-1:0]   bp;
      logic [CYCLES_W-1:0]   fc;
      logic                  bon;
      int                    j;
      int                    items;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_tick     = 1'b0;
      req_boost_on = 1'b0;
      csr_we       = 1'b0;
      csr_index    = CSR_FLASH_PERIOD;
      csr_wdata    = '0;
      calm         = 1'b0;
      idle_cycles  = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // reset settings: slow flash not yet toggled, LED2 off
      send_request(1'b0, 1'b0);
      send_request(1'b1, 1'b1);

      // fastest flash, stopping after two flashes; LED2 steady on
      wait_for_drain();
      write_csr(CSR_FLASH_PERIOD, 16'd1);
      write_csr(CSR_FLASH_CYCLES, 16'd2);
      write_csr(CSR_BREATH_ON, 16'hFFFF);
      write_csr(CSR_BREATH_PERIOD, 16'd0);
      finish_writes();
      repeat (5) send_request(1'b1, 1'b1);

      // one-tick breath period, boost low holds, status query changes nothing
      wait_for_drain();
      write_csr(CSR_BREATH_PERIOD, 16'd1);
      finish_writes();
      send_request(1'b1, 1'b1);
      send_request(1'b1, 1'b0);
      send_request(1'b0, 1'b1);
      send_request(1'b1, 1'b1);

      // static LED1 level, wide cycles value truncated, longest breath period
      wait_for_drain();
      write_csr(CSR_FLASH_PERIOD, 16'd0);
      write_csr(CSR_FLASH_CYCLES, 16'hFF03);
      write_csr(CSR_BREATH_PERIOD, 16'hFFFF);
      finish_writes();
      send_request(1'b1, 1'b1);
      send_request(1'b1, 1'b1);
      send_request(1'b0, 1'b0);

      // breathing off via a wide value, write to a spare index, extremes of LED1
      wait_for_drain();
      write_csr(CSR_BREATH_ON, 16'hFFFE);
      write_csr(CSR_SPARE_HI, 16'hFFFF);
      write_csr(CSR_FLASH_PERIOD, 16'hFFFF);
      write_csr(CSR_FLASH_CYCLES, 16'h00FF);
      finish_writes();
      send_request(1'b1, 1'b1);
      send_request(1'b1, 1'b0);
      send_request(1'b0, 1'b1);

      // quarter-turn steps reach the sine peak and trough
      wait_for_drain();
      write_csr(CSR_BREATH_PERIOD, 16'd4);
      write_csr(CSR_BREATH_ON, 16'd1);
      finish_writes();
      repeat (5) send_request(1'b1, 1'b1);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_drain();
         calm = ($urandom_range(0, 3) == 0);

         case ($urandom_range(0, 9))
            0:       fp = '0;
            1:       fp = '1;
            2:       fp = PERIOD_W'($urandom_range(13, 65535));
            default: fp = PERIOD_W'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 5))
            0:       fc = '0;
            1:       fc = '1;
            default: fc = CYCLES_W'($urandom_range(1, 8));
         endcase
         bon = ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 9))
            0:       bp = '0;
            1:       bp = '1;
            2:       bp = PERIOD_W'($urandom_range(101, 4096));
            default: bp = PERIOD_W'($urandom_range(1, 100));
         endcase

         order = '{CSR_FLASH_PERIOD, CSR_FLASH_CYCLES, CSR_BREATH_ON, CSR_BREATH_PERIOD};
         for (int k = 3; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
         end
         foreach (order[k]) begin
            case (order[k])
               CSR_FLASH_PERIOD: data = fp;
               CSR_FLASH_CYCLES: data = {8'($urandom), fc};
               CSR_BREATH_ON:    data = {15'($urandom), bon};
               default:          data = bp;
            endcase
            // now and then a register keeps its old value
            if ($urandom_range(0, 9) != 0) begin
               write_csr(order[k], data);
            end
         end
         if ($urandom_range(0, 4) == 0) begin
            write_csr(CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                      CSR_DATA_W'($urandom));
         end
         finish_writes();

         items = $urandom_range(130, 170);
         for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 49) == 0) begin
               wait_for_drain();
            end
            send_request($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85);
         end
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (levels.pending() != 0) begin
         levels.report($sformatf("%0d responses never arrived", levels.pending()));
      end
      if (levels.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/lfb_pkg.sv
hdl/lfb_ctrl.sv
hdl/lfb_dp.sv
hdl/led_flash_and_breath_driver.sv
tb/sv/led_flash_and_breath_driver_tb.sv
